/* sv/assert_macros.svh */
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/medf_pkg.sv */
package medf_pkg;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int CHANNELS = 3;

    localparam int CFG_W_WIDTH  = 11;
    localparam int CFG_H_WIDTH  = 13;
    localparam int CFG_S_WIDTH  = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_FEED,
        ST_HOLD
    } medf_state_t;

    // Link between neighboring sorter cells.
    typedef struct packed {
        logic [PIX_W-1:0]    val;
        logic                valid;
        logic [CHANNELS-1:0] le;
    } medf_link_t;

endpackage

/* sv/median_filter_rgb.sv */
// A pixel with a result goes through LOAD, PREP, FEED and HOLD into the output
// register; in FEED the window, MAX_WINDOW rounded down to odd, is fed one pixel
// a cycle through the sorting cell chain. A border pixel goes from LOAD to IDLE.
// A new pixel is taken only in IDLE; HOLD waits for the output register to free.
// Reset: counters clear to zero, registers load 640 x 480 with window 3;
// line memory and window contents are undefined until written.
`include "assert_macros.svh"

module median_filter_rgb
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_WINDOW = 7
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [medf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [medf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [medf_pkg::CH_W-1:0]           in_blue,
    input  logic [medf_pkg::CH_W-1:0]           in_green,
    input  logic [medf_pkg::CH_W-1:0]           in_red,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic [medf_pkg::CH_W-1:0]           out_blue,
    output logic [medf_pkg::CH_W-1:0]           out_green,
    output logic [medf_pkg::CH_W-1:0]           out_red,
    output logic                                frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SW    = $clog2(MAX_WINDOW + 1);
    localparam int PW    = medf_pkg::PIX_W;
    localparam int MW    = MAX_WINDOW;
    localparam int WO    = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int WOFF  = MAX_WINDOW - WO;
    localparam int NC    = WO * WO;
    localparam int FW    = $clog2(NC + 1);
    localparam int LROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;

    // Configuration
    logic [medf_pkg::CFG_W_WIDTH-1:0] cfg_w_reg;
    logic [medf_pkg::CFG_H_WIDTH-1:0] cfg_h_reg;
    logic [medf_pkg::CFG_S_WIDTH-1:0] cfg_s_reg;
    logic                             cfg_hit;

    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic [SW-1:0] s_eff;

    // Control
    medf_pkg::medf_state_t st_reg;
    medf_pkg::medf_state_t st_next;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] cur_c_reg;
    logic [RW-1:0] cur_r_reg;
    logic [CW-1:0] cur_c;
    logic [RW-1:0] cur_r;

    logic [PW-1:0] pix_reg;
    logic          has_res;
    logic          is_last;
    logic [SW-1:0] half;

    logic [RW-1:0] pend_row_reg;
    logic [CW-1:0] pend_col_reg;
    logic          pend_last_reg;

    logic          accept;
    logic          sort_clear;
    logic          sort_ins;
    logic          out_load;
    logic          mem_wr;

    // Line memory and window
    logic [LROWS*PW-1:0] rd_data;
    logic [LROWS*PW-1:0] wr_data;
    logic [PW-1:0]       win_reg [MW][MW];
    logic [PW-1:0]       col_in [MW];

    // Feed chain
    logic [PW-1:0] feed_pix_reg [NC];
    logic          feed_inc_reg [NC];
    logic [FW-1:0] feed_cnt_reg;
    logic          pad_reg;
    logic [PW-1:0] sort_x;
    logic [PW-1:0] median;
    logic          sort_full;

    // Output register
    logic          out_valid_reg;
    logic [RW-1:0] out_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [PW-1:0] out_pix_reg;
    logic          out_last_reg;

    // Effective dimensions
    always_comb
    begin
        logic [31:0] wt;
        logic [31:0] ht;
        logic [31:0] st;
        wt = 32'(cfg_w_reg);
        ht = 32'(cfg_h_reg);
        st = 32'(cfg_s_reg);
        if (wt == 32'd0)
        begin
            wt = 32'd1;
        end
        else if (wt > 32'(MAX_WIDTH))
        begin
            wt = 32'(MAX_WIDTH);
        end
        if (ht == 32'd0)
        begin
            ht = 32'd1;
        end
        else if (ht > 32'(MAX_HEIGHT))
        begin
            ht = 32'(MAX_HEIGHT);
        end
        if (st > 32'(MAX_WINDOW))
        begin
            st = 32'(MAX_WINDOW);
        end
        if (st == 32'd0)
        begin
            st = 32'd1;
        end
        else if (!st[0])
        begin
            st = st - 32'd1;
        end
        w_eff = (CW+1)'(wt);
        h_eff = (RW+1)'(ht);
        s_eff = SW'(st);
    end

    assign cfg_hit = cfg_we && (cfg_addr == medf_pkg::REG_WIDTH ||
                                cfg_addr == medf_pkg::REG_HEIGHT ||
                                cfg_addr == medf_pkg::REG_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= medf_pkg::CFG_W_WIDTH'(640);
            cfg_h_reg <= medf_pkg::CFG_H_WIDTH'(480);
            cfg_s_reg <= medf_pkg::CFG_S_WIDTH'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                medf_pkg::REG_WIDTH:
                begin
                    cfg_w_reg <= cfg_data[medf_pkg::CFG_W_WIDTH-1:0];
                end
                medf_pkg::REG_HEIGHT:
                begin
                    cfg_h_reg <= cfg_data[medf_pkg::CFG_H_WIDTH-1:0];
                end
                medf_pkg::REG_WINDOW:
                begin
                    cfg_s_reg <= cfg_data[medf_pkg::CFG_S_WIDTH-1:0];
                end
                default:
                begin
                    cfg_w_reg <= cfg_w_reg;
                end
            endcase
        end
    end

    // Position of the incoming pixel, wrapped against the current size.
    assign cur_c = (32'(col_reg) >= 32'(w_eff)) ? '0 : col_reg;
    assign cur_r = (32'(row_reg) >= 32'(h_eff)) ? '0 : row_reg;

    assign half = (s_eff - SW'(1)) >> 1;

    always_comb
    begin
        has_res = (32'(s_eff) <= 32'(w_eff)) && (32'(s_eff) <= 32'(h_eff)) &&
                  (32'(cur_r_reg) + 32'd1 >= 32'(s_eff)) &&
                  (32'(cur_c_reg) + 32'd1 >= 32'(s_eff));
        is_last = (32'(cur_r_reg) + 32'd1 == 32'(h_eff)) &&
                  (32'(cur_c_reg) + 32'd1 == 32'(w_eff));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (st_reg == medf_pkg::ST_LOAD)
        begin
            if (32'(cur_c_reg) + 32'd1 >= 32'(w_eff))
            begin
                col_next = '0;
                if (32'(cur_r_reg) + 32'd1 >= 32'(h_eff))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = cur_r_reg + RW'(1);
                end
            end
            else
            begin
                col_next = cur_c_reg + CW'(1);
                row_next = cur_r_reg;
            end
        end
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            medf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = medf_pkg::ST_LOAD;
                end
            end
            medf_pkg::ST_LOAD:
            begin
                st_next = has_res ? medf_pkg::ST_PREP : medf_pkg::ST_IDLE;
            end
            medf_pkg::ST_PREP:
            begin
                st_next = medf_pkg::ST_FEED;
            end
            medf_pkg::ST_FEED:
            begin
                if (feed_cnt_reg == FW'(NC - 1))
                begin
                    st_next = medf_pkg::ST_HOLD;
                end
            end
            medf_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    st_next = medf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = medf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready   = 1'b0;
        mem_wr     = 1'b0;
        sort_clear = 1'b0;
        sort_ins   = 1'b0;
        out_load   = 1'b0;
        case (st_reg)
            medf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            medf_pkg::ST_LOAD:
            begin
                mem_wr = 1'b1;
            end
            medf_pkg::ST_PREP:
            begin
                sort_clear = 1'b1;
            end
            medf_pkg::ST_FEED:
            begin
                sort_ins = 1'b1;
            end
            medf_pkg::ST_HOLD:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= medf_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            feed_cnt_reg  <= '0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            col_reg <= col_next;
            row_reg <= row_next;
            if (sort_clear)
            begin
                feed_cnt_reg <= '0;
                pad_reg      <= 1'b0;
            end
            else if (sort_ins)
            begin
                feed_cnt_reg <= feed_cnt_reg + FW'(1);
                // alternate low and high pads so the median stays centered
                if (!feed_inc_reg[0])
                begin
                    pad_reg <= !pad_reg;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat capture and pending result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= {in_red, in_green, in_blue};
            cur_c_reg <= cur_c;
            cur_r_reg <= cur_r;
        end
        if (st_reg == medf_pkg::ST_LOAD)
        begin
            pend_row_reg  <= cur_r_reg - RW'(half);
            pend_col_reg  <= cur_c_reg - CW'(half);
            pend_last_reg <= is_last;
        end
        if (out_load)
        begin
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_pix_reg  <= median;
            out_last_reg <= pend_last_reg;
        end
    end

    // Line delays: slot 0 takes the new pixel, each older row moves down one.
    assign wr_data[PW-1:0] = pix_reg;
    for (genvar k = 1; k < LROWS; k++)
    begin : g_wr
        assign wr_data[k*PW +: PW] = rd_data[(k-1)*PW +: PW];
    end

    medf_line
    #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LROWS * PW)
    )
    u_line
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_c),
        .rd_data (rd_data),
        .wr_en   (mem_wr),
        .wr_addr (cur_c_reg),
        .wr_data (wr_data)
    );

    // New right-hand window column: oldest row on top, current pixel at bottom.
    for (genvar rr = 0; rr < MW; rr++)
    begin : g_col
        if (rr == MW - 1)
        begin : g_cur
            assign col_in[rr] = pix_reg;
        end
        else
        begin : g_old
            assign col_in[rr] = rd_data[(MW-2-rr)*PW +: PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == medf_pkg::ST_LOAD)
        begin
            for (int rr = 0; rr < MW; rr++)
            begin
                for (int cc = 0; cc < MW - 1; cc++)
                begin
                    win_reg[rr][cc] <= win_reg[rr][cc+1];
                end
                win_reg[rr][MW-1] <= col_in[rr];
            end
        end
    end

    // Feed chain: snapshot the window, then shift one pixel per cycle.
    for (genvar k = 0; k < NC; k++)
    begin : g_feed
        localparam int FI = k / WO;
        localparam int FJ = k % WO;
        always_ff @(posedge clk)
        begin
            if (sort_clear)
            begin
                feed_pix_reg[k] <= win_reg[WOFF+FI][WOFF+FJ];
                feed_inc_reg[k] <= (32'(FI) + 32'(s_eff) >= 32'(WO)) &&
                                   (32'(FJ) + 32'(s_eff) >= 32'(WO));
            end
            else if (sort_ins)
            begin
                if (k < NC - 1)
                begin
                    feed_pix_reg[k] <= feed_pix_reg[(k < NC - 1) ? k + 1 : k];
                    feed_inc_reg[k] <= feed_inc_reg[(k < NC - 1) ? k + 1 : k];
                end
            end
        end
    end

    assign sort_x = feed_inc_reg[0] ? feed_pix_reg[0] : {PW{pad_reg}};

    medf_sorter
    #(
        .NCELLS (NC)
    )
    u_sorter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (sort_clear),
        .ins    (sort_ins),
        .x      (sort_x),
        .median (median),
        .full   (sort_full)
    );

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_blue   = out_pix_reg[0 +: medf_pkg::CH_W];
    assign out_green  = out_pix_reg[medf_pkg::CH_W +: medf_pkg::CH_W];
    assign out_red    = out_pix_reg[2*medf_pkg::CH_W +: medf_pkg::CH_W];
    assign frame_last = out_last_reg;

    `CHK_NEXT(a_accept_to_load, in_valid && in_ready, st_reg == medf_pkg::ST_LOAD, "beat not loaded")
    `CHK_SAME(a_sorter_full, st_reg == medf_pkg::ST_HOLD, sort_full, "sorter not full at hold")
    `CHK_SAME(a_feed_range, st_reg == medf_pkg::ST_FEED, feed_cnt_reg < FW'(NC), "feed overrun")

endmodule

/* sv/medf_cell.sv */
module medf_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        ins,
    input  logic [medf_pkg::PIX_W-1:0]  x,
    input  medf_pkg::medf_link_t        prev,
    output medf_pkg::medf_link_t        link
);

    logic [medf_pkg::PIX_W-1:0]    val_reg;
    logic [medf_pkg::PIX_W-1:0]    val_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [medf_pkg::CHANNELS-1:0] le;

    always_comb
    begin
        for (int ch = 0; ch < medf_pkg::CHANNELS; ch++)
        begin
            le[ch] = valid_reg &&
                (val_reg[ch*medf_pkg::CH_W +: medf_pkg::CH_W] <=
                 x[ch*medf_pkg::CH_W +: medf_pkg::CH_W]);
        end
    end

    // Each lane sorts on its own: keep if not above x, else take x or shift up.
    always_comb
    begin
        val_next = val_reg;
        if (ins)
        begin
            for (int ch = 0; ch < medf_pkg::CHANNELS; ch++)
            begin
                if (!le[ch])
                begin
                    val_next[ch*medf_pkg::CH_W +: medf_pkg::CH_W] = prev.le[ch] ?
                        x[ch*medf_pkg::CH_W +: medf_pkg::CH_W] :
                        prev.val[ch*medf_pkg::CH_W +: medf_pkg::CH_W];
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (ins)
        begin
            valid_next = prev.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val   = val_reg;
    assign link.valid = valid_reg;
    assign link.le    = le;

endmodule

/* sv/medf_sorter.sv */
module medf_sorter
#(
    parameter int NCELLS = 49
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        ins,
    input  logic [medf_pkg::PIX_W-1:0]  x,
    output logic [medf_pkg::PIX_W-1:0]  median,
    output logic                        full
);

    localparam int MID = (NCELLS - 1) / 2;

    medf_pkg::medf_link_t links [NCELLS+1];

    assign links[0].val   = '0;
    assign links[0].valid = 1'b1;
    assign links[0].le    = '1;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        medf_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (clear),
            .ins   (ins),
            .x     (x),
            .prev  (links[i]),
            .link  (links[i+1])
        );
    end

    assign median = links[MID+1].val;
    assign full   = links[NCELLS].valid;

endmodule

/* sv/medf_line.sv */
module medf_line
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 144
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
